// ----- hw/rtl/bcbf_pkg.sv -----
`timescale 1ns / 1ps

package bcbf_pkg;

  // Coefficient format: signed Q2.30
  localparam int COEF_BITS   = 32;
  localparam int FRAC_BITS   = 30;

  // Configuration file: numerator and denominator word per section slot
  localparam int CFG_BITS     = 64;
  localparam int CFG_IDX_BITS = 3;
  localparam int MAX_SECTIONS = 4;
  localparam int SLOT_BITS    = 2;

  localparam logic [CFG_BITS-1:0] NUM_RESET = 64'd1073741824;  // b0 = 1.0
  localparam logic [CFG_BITS-1:0] DEN_RESET = 64'd0;

  // Parameter defaults
  localparam int SECTIONS_DEF    = 4;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int STATE_BITS_DEF  = 24;

  typedef struct packed {
    logic [CFG_BITS-1:0] den;  // a2 in 63:32, a1 in 31:0
    logic [CFG_BITS-1:0] num;  // b1 in 63:32, b0/b2 in 31:0
  } cfg_slot_t;

  // Control from the sequencer to the shared MAC
  typedef struct packed {
    logic mul;  // launch a product this cycle
    logic sub;  // product is subtracted (feedback term)
    logic clr;  // clear accumulator at the start of a section
  } mac_ctl_t;

endpackage

// ----- hw/rtl/bcbf_mac.sv -----
`timescale 1ns / 1ps

module bcbf_mac #(
  parameter int STATE_BITS = bcbf_pkg::STATE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bcbf_pkg::mac_ctl_t           ctl_i,
  input  logic signed [bcbf_pkg::COEF_BITS-1:0] coef_i,
  input  logic signed [STATE_BITS-1:0] data_i,
  output logic signed [STATE_BITS-1:0] y_o
);

  localparam int CW = bcbf_pkg::COEF_BITS;
  localparam int FW = bcbf_pkg::FRAC_BITS;
  localparam int PW = CW + STATE_BITS;
  // five products plus the rounding constant
  localparam int AW = PW + 3;
  localparam int SW = AW - FW;

  logic signed [PW-1:0] prod_d, prod_q;
  logic                 pv_q, psub_q;
  logic signed [AW-1:0] acc_q, addend, rnd;
  logic signed [SW-1:0] shr;
  logic [SW-STATE_BITS:0] top_bits;
  logic                 in_range;

  assign prod_d = coef_i * data_i;
  assign addend = $signed({{(AW-PW){prod_q[PW-1]}}, prod_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= 1'b0;
      psub_q <= 1'b0;
    end else begin
      pv_q   <= ctl_i.mul;
      psub_q <= ctl_i.sub;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul) begin
      prod_q <= prod_d;
    end
    if (ctl_i.clr) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= psub_q ? acc_q - addend : acc_q + addend;
    end
  end

  // round half up at the binary point, then saturate
  assign rnd      = acc_q + $signed({{(AW-FW){1'b0}}, 1'b1, {(FW-1){1'b0}}});
  assign shr      = rnd[AW-1:FW];
  assign top_bits = shr[SW-1:STATE_BITS-1];
  assign in_range = (&top_bits) | ~(|top_bits);

  always_comb begin
    if (in_range) begin
      y_o = shr[STATE_BITS-1:0];
    end else if (shr[SW-1]) begin
      y_o = $signed({1'b1, {(STATE_BITS-1){1'b0}}});
    end else begin
      y_o = $signed({1'b0, {(STATE_BITS-1){1'b1}}});
    end
  end

endmodule

// ----- hw/rtl/biquad_cascade_band_filter_unit.sv -----
`timescale 1ns / 1ps

// Cascade of SECTIONS second-order IIR sections (direct form I) on a stream of
// signed samples. Each sample is scaled into STATE_BITS-wide state, passes
// every section in turn (y = b0*x + b1*x1 + b0*x2 - a1*y1 - a2*y2, full-width
// sum, round half up at bit 30, saturate), and is scaled back with rounding
// and saturation. One 32 x STATE_BITS multiplier with an accumulator does all
// the products: five per section, then a step to drain the last product and
// one to round and update the section state. A new item is accepted only after
// the last has passed every section; the output register lets the next item
// start while a result waits. The user must write coefficients on the cfg port
// only while idle (the block does not enforce it): index 2k is section k's
// numerator (b1 in 63:32, b0 = b2 in 31:0), index 2k+1 its denominator (a2 in
// 63:32, a1 in 31:0), all signed Q2.30. After reset b0 = 1.0 and all else 0,
// so each section gives x + x2.
module biquad_cascade_band_filter_unit #(
  parameter int SECTIONS    = bcbf_pkg::SECTIONS_DEF,
  parameter int SAMPLE_BITS = bcbf_pkg::SAMPLE_BITS_DEF,
  parameter int STATE_BITS  = bcbf_pkg::STATE_BITS_DEF,
  localparam int TDW        = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [bcbf_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [bcbf_pkg::CFG_BITS-1:0]     cfg_wdata_i,
  // input stream
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [TDW-1:0]                    s_axis_tdata_i,   // sample_in
  // output stream
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [TDW-1:0]                    m_axis_tdata_o    // sample_out
);

  localparam int XW    = STATE_BITS;
  localparam int SW    = SAMPLE_BITS;
  localparam int CW    = bcbf_pkg::COEF_BITS;
  localparam int DIFF  = STATE_BITS - SAMPLE_BITS;
  localparam int SECW  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int SlotW = bcbf_pkg::SLOT_BITS;

  // top-level states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // steps within one section
  localparam logic [2:0] ST_B0X  = 3'd0;
  localparam logic [2:0] ST_B1X1 = 3'd1;
  localparam logic [2:0] ST_B0X2 = 3'd2;
  localparam logic [2:0] ST_A1Y1 = 3'd3;
  localparam logic [2:0] ST_A2Y2 = 3'd4;
  localparam logic [2:0] ST_DRN  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [1:0]      state_q, state_d;
  logic [2:0]      st_q;
  logic [SECW-1:0] sec_q;

  bcbf_pkg::cfg_slot_t cfg_q [bcbf_pkg::MAX_SECTIONS];
  bcbf_pkg::cfg_slot_t slot;

  logic signed [XW-1:0] x1_q [SECTIONS];
  logic signed [XW-1:0] x2_q [SECTIONS];
  logic signed [XW-1:0] y1_q [SECTIONS];
  logic signed [XW-1:0] y2_q [SECTIONS];

  logic signed [XW-1:0] cur_q;   // sample entering the current section
  logic signed [XW-1:0] v_in;    // input sample scaled to state width
  logic signed [SW-1:0] v_out;   // final state scaled back to sample width
  logic signed [SW-1:0] samp;
  logic [SW-1:0]        out_q;
  logic                 out_vld_q;

  bcbf_pkg::mac_ctl_t   ctl;
  logic signed [CW-1:0] coef;
  logic signed [XW-1:0] opnd;
  logic signed [XW-1:0] y_sec;

  logic in_acc, out_free, last_sec;

  assign samp            = $signed(s_axis_tdata_i[SW-1:0]);
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = ~out_vld_q | m_axis_tready_i;
  assign last_sec        = (sec_q == SECW'(SECTIONS - 1));
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = TDW'(out_q);

  // ---------------- input and output scaling ----------------
  generate
    if (DIFF >= 0) begin : g_in_up
      assign v_in = XW'(samp) <<< DIFF;
    end else begin : g_in_down
      localparam int K  = -DIFF;
      localparam int TW = SW + 1;
      logic signed [TW-1:0]   t;
      logic signed [TW-K-1:0] s;
      logic [TW-K-XW:0]       hi;
      assign t  = TW'(samp) + $signed(TW'(1) << (K - 1));
      assign s  = t[TW-1:K];
      assign hi = s[TW-K-1:XW-1];
      assign v_in = ((&hi) | ~(|hi)) ? s[XW-1:0] :
                    (s[TW-K-1] ? $signed({1'b1, {(XW-1){1'b0}}})
                               : $signed({1'b0, {(XW-1){1'b1}}}));
    end

    if (DIFF > 0) begin : g_out_down
      localparam int TW = XW + 1;
      logic signed [TW-1:0]      t;
      logic signed [TW-DIFF-1:0] s;
      logic [TW-DIFF-SW:0]       hi;
      assign t  = TW'(cur_q) + $signed(TW'(1) << (DIFF - 1));
      assign s  = t[TW-1:DIFF];
      assign hi = s[TW-DIFF-1:SW-1];
      assign v_out = ((&hi) | ~(|hi)) ? s[SW-1:0] :
                     (s[TW-DIFF-1] ? $signed({1'b1, {(SW-1){1'b0}}})
                                   : $signed({1'b0, {(SW-1){1'b1}}}));
    end else begin : g_out_up
      assign v_out = SW'(cur_q) <<< (-DIFF);
    end
  endgenerate

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bcbf_pkg::MAX_SECTIONS; i++) begin
        cfg_q[i].num <= bcbf_pkg::NUM_RESET;
        cfg_q[i].den <= bcbf_pkg::DEN_RESET;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i[0]) begin
        cfg_q[cfg_idx_i[bcbf_pkg::CFG_IDX_BITS-1:1]].den <= cfg_wdata_i;
      end else begin
        cfg_q[cfg_idx_i[bcbf_pkg::CFG_IDX_BITS-1:1]].num <= cfg_wdata_i;
      end
    end
  end

  assign slot = cfg_q[SlotW'(sec_q)];

  // ---------------- operand select for the shared MAC ----------------
  always_comb begin
    ctl.mul = (state_q == S_RUN) && (st_q <= ST_A2Y2);
    ctl.sub = (st_q == ST_A1Y1) || (st_q == ST_A2Y2);
    ctl.clr = (state_q == S_RUN) && (st_q == ST_B0X);
    unique case (st_q)
      ST_B0X: begin
        coef = $signed(slot.num[CW-1:0]);
        opnd = cur_q;
      end
      ST_B1X1: begin
        coef = $signed(slot.num[2*CW-1:CW]);
        opnd = x1_q[sec_q];
      end
      ST_B0X2: begin
        coef = $signed(slot.num[CW-1:0]);
        opnd = x2_q[sec_q];
      end
      ST_A1Y1: begin
        coef = $signed(slot.den[CW-1:0]);
        opnd = y1_q[sec_q];
      end
      ST_A2Y2: begin
        coef = $signed(slot.den[2*CW-1:CW]);
        opnd = y2_q[sec_q];
      end
      default: begin
        coef = '0;
        opnd = '0;
      end
    endcase
  end

  bcbf_mac #(
    .STATE_BITS(STATE_BITS)
  ) u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ctl),
    .coef_i(coef),
    .data_i(opnd),
    .y_o   (y_sec)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_RUN;
      S_RUN:  if (st_q == ST_FIN && last_sec) state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_B0X;
      sec_q   <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        st_q  <= ST_B0X;
        sec_q <= '0;
      end else if (state_q == S_RUN) begin
        if (st_q == ST_FIN) begin
          st_q  <= ST_B0X;
          // back to section 0 after the last one so the counters rest at zero
          sec_q <= last_sec ? '0 : sec_q + SECW'(1);
        end else begin
          st_q <= st_q + 3'd1;
        end
      end
    end
  end

  // section history, written when a section finishes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SECTIONS; i++) begin
        x1_q[i] <= '0;
        x2_q[i] <= '0;
        y1_q[i] <= '0;
        y2_q[i] <= '0;
      end
    end else if (state_q == S_RUN && st_q == ST_FIN) begin
      x2_q[sec_q] <= x1_q[sec_q];
      x1_q[sec_q] <= cur_q;
      y2_q[sec_q] <= y1_q[sec_q];
      y1_q[sec_q] <= y_sec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_q <= v_in;
    end else if (state_q == S_RUN && st_q == ST_FIN) begin
      cur_q <= y_sec;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      out_q <= v_out;
    end
  end

  // ---------------- assertions ----------------
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o)
    else $error("input taken while a sample is in flight");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (st_q <= ST_FIN))
    else $error("section step out of range");

  a_idle_counters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (st_q == ST_B0X && sec_q == '0))
    else $error("sequencer counters not at rest while idle");

  a_done_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> m_axis_tvalid_o)
    else $error("finished sample not presented");

endmodule
